>>> src/tjt_pkg.sv
// Shared types, codes and sizes for the timer job table.
package tjt_pkg;

   localparam int JOBS  = 16;
   localparam int IDX_W = $clog2(JOBS);
   localparam int ID_W  = 4;
   localparam int RES_W = 8;
   localparam int DLY_W = 24;
   localparam int SDLY_W = 23;

   localparam logic [DLY_W-1:0] MAX_DELAY = 24'd8000000;

   // commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // job kinds
   localparam logic [1:0] KIND_ONESHOT  = 2'd0;
   localparam logic [1:0] KIND_PERIODIC = 2'd1;

   // result status
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_FULL      = 3'd1;
   localparam logic [2:0] STS_BAD_DELAY = 3'd2;
   localparam logic [2:0] STS_BAD_KIND  = 3'd3;
   localparam logic [2:0] STS_NO_ID     = 3'd4;

   typedef struct packed {
      logic              periodic;
      logic [SDLY_W-1:0] delay;
      logic [DLY_W-1:0]  elapsed;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef struct packed {
      logic           hit;   // elapsed reached the delay on this tick
      logic           keep;  // slot stays valid afterwards
      slot_entry_type entry; // value to write back
   } slot_upd_type;

endpackage

>>> src/timer_job_table.sv
// Timer job table top level: command sequencer around the slot RAM.
//
// Input channel req_*: one command per transfer (start, stop, tick; code 3 is
// dropped without a result). Result channel rsp_*: start and stop give one
// result each; a tick gives one result per expired job in slot order, or a
// single empty result when nothing expires. rsp_tlast marks the final result
// of a command. csr_wr_en/csr_wr_data set the tick resolution (reset 1).
//
// Slot fields (delay, elapsed, periodic) sit in one RAM; valid bits are flops.
// Start and stop go through S_CMD, which registers the result when the output
// register is free. A tick walks slots 1..JOBS-1 at one slot per cycle unless
// stalled, via the RAM read port (next-slot read overlaps current write-back).
// One command is in flight at a time; the next is accepted once the previous
// one has handed its last result to the output register.
// Reset empties the table at once (valid bits cleared) and drops any result.
// If the receiver stalls, the result stays in the output register and a tick
// walk pauses on an expiry with an earlier one held, until the register frees.
module timer_job_table import tjt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // delay_ms[23:0], job_kind[25:24], job_id[29:26]
   input  logic [1:0]       req_tuser,   // command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // status[2:0], result_id[6:3]
   output logic [0:0]       rsp_tuser,   // expired
   output logic             rsp_tlast,
   input  logic             csr_wr_en,
   input  logic [RES_W-1:0] csr_wr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMD  = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(JOBS - 1);

   logic [1:0]       state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [DLY_W-1:0] delay_ff, delay_in;
   logic [1:0]       kind_ff, kind_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [JOBS-1:0]  valid_ff, valid_in;
   logic             hold_v_ff, hold_v_in;
   logic [IDX_W-1:0] hold_id_ff, hold_id_in;
   logic [RES_W-1:0] res_ff, res_in;

   logic             rsp_v_ff, rsp_v_in;
   logic [2:0]       rsp_sts_ff, rsp_sts_in;
   logic [ID_W-1:0]  rsp_id_ff, rsp_id_in;
   logic             rsp_exp_ff, rsp_exp_in;
   logic             rsp_last_ff, rsp_last_in;

   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   slot_entry_type       ram_wdata, ram_rdata;
   logic [ENTRY_W-1:0]   ram_rdata_raw;
   slot_upd_type         upd;

   logic             out_free;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic [IDX_W-1:0] stop_idx;
   logic             stop_ok;
   logic             walk_stall;
   logic [2:0]       start_sts;

   tjt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (JOBS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = slot_entry_type'(ram_rdata_raw);

   tjt_slot_upd u_upd (
      .entry      (ram_rdata),
      .valid      (valid_ff[slot_ff]),
      .resolution (res_ff),
      .upd        (upd)
   );

   assign out_free   = !rsp_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   // lowest free slot above the reserved one
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = JOBS - 1; s >= 1; s--) begin
         if (!valid_ff[s]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(s);
         end
      end
   end

   always_comb begin
      stop_idx = IDX_W'(id_ff);
      stop_ok  = (id_ff != '0) && (int'(id_ff) < JOBS) && valid_ff[stop_idx];
      priority if (!free_found) begin
         start_sts = STS_FULL;
      end else if (delay_ff > MAX_DELAY) begin
         start_sts = STS_BAD_DELAY;
      end else if (kind_ff != KIND_ONESHOT && kind_ff != KIND_PERIODIC) begin
         start_sts = STS_BAD_KIND;
      end else begin
         start_sts = STS_OK;
      end
   end

   assign walk_stall = upd.hit && hold_v_ff && !out_free;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      delay_in    = delay_ff;
      kind_in     = kind_ff;
      id_in       = id_ff;
      slot_in     = slot_ff;
      valid_in    = valid_ff;
      hold_v_in   = hold_v_ff;
      hold_id_in  = hold_id_ff;
      res_in      = csr_wr_en ? csr_wr_data : res_ff;

      rsp_v_in    = rsp_v_ff && !rsp_tready;
      rsp_sts_in  = rsp_sts_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_exp_in  = rsp_exp_ff;
      rsp_last_in = rsp_last_ff;

      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = upd.entry;
      ram_re    = 1'b0;
      ram_raddr = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               delay_in = req_tdata[23:0];
               kind_in  = req_tdata[25:24];
               id_in    = req_tdata[29:26];
               unique case (req_tuser)
                  CMD_START, CMD_STOP: state_in = S_CMD;
                  CMD_TICK: begin
                     slot_in   = IDX_W'(1);
                     ram_re    = 1'b1;
                     ram_raddr = IDX_W'(1);
                     hold_v_in = 1'b0;
                     state_in  = S_WALK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CMD: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_exp_in  = 1'b0;
               rsp_last_in = 1'b1;
               rsp_id_in   = '0;
               if (cmd_ff == CMD_START) begin
                  rsp_sts_in = start_sts;
                  if (start_sts == STS_OK) begin
                     ram_we                 = 1'b1;
                     ram_waddr              = free_idx;
                     ram_wdata.periodic     = (kind_ff == KIND_PERIODIC);
                     ram_wdata.delay        = delay_ff[SDLY_W-1:0];
                     ram_wdata.elapsed      = '0;
                     valid_in[free_idx]     = 1'b1;
                     rsp_id_in              = ID_W'(free_idx);
                  end
               end else begin
                  if (stop_ok) begin
                     valid_in[stop_idx] = 1'b0;
                     rsp_sts_in         = STS_OK;
                  end else begin
                     rsp_sts_in         = STS_NO_ID;
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (!walk_stall) begin
               if (valid_ff[slot_ff]) begin
                  ram_we = 1'b1;
                  if (!upd.keep) begin
                     valid_in[slot_ff] = 1'b0;
                  end
               end
               if (upd.hit) begin
                  // previous expiry is now known not to be the last one
                  if (hold_v_ff) begin
                     rsp_v_in    = 1'b1;
                     rsp_sts_in  = STS_OK;
                     rsp_id_in   = ID_W'(hold_id_ff);
                     rsp_exp_in  = 1'b1;
                     rsp_last_in = 1'b0;
                  end
                  hold_v_in  = 1'b1;
                  hold_id_in = slot_ff;
               end
               if (slot_ff == LAST_SLOT) begin
                  state_in = S_DONE;
               end else begin
                  slot_in   = slot_ff + IDX_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = slot_ff + IDX_W'(1);
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_v_in    = 1'b1;
               rsp_sts_in  = STS_OK;
               rsp_id_in   = hold_v_ff ? ID_W'(hold_id_ff) : '0;
               rsp_exp_in  = hold_v_ff;
               rsp_last_in = 1'b1;
               hold_v_in   = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         hold_v_ff <= 1'b0;
         res_ff    <= RES_W'(1);
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         hold_v_ff <= hold_v_in;
         res_ff    <= res_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      delay_ff    <= delay_in;
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      slot_ff     <= slot_in;
      hold_id_ff  <= hold_id_in;
      rsp_sts_ff  <= rsp_sts_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {1'b0, rsp_id_ff, rsp_sts_ff};
   assign rsp_tuser  = rsp_exp_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> src/tjt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tjt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tjt_slot_upd.sv
// Per-slot tick update: advance elapsed time and detect expiry.
module tjt_slot_upd import tjt_pkg::*; (
   input  slot_entry_type   entry,
   input  logic             valid,
   input  logic [RES_W-1:0] resolution,
   output slot_upd_type     upd
);

   logic [DLY_W:0]   sum;
   logic [DLY_W-1:0] elapsed_new;
   logic             hit;

   always_comb begin
      sum         = {1'b0, entry.elapsed} + (DLY_W+1)'(resolution);
      elapsed_new = sum[DLY_W-1:0];
      hit         = valid && (elapsed_new >= DLY_W'(entry.delay));

      upd.hit              = hit;
      upd.keep             = valid && !(hit && !entry.periodic);
      upd.entry.periodic   = entry.periodic;
      upd.entry.delay      = entry.delay;
      upd.entry.elapsed    = hit ? '0 : elapsed_new;
   end

endmodule

>>> src/tjt_checker.sv
// Port-level checks for the timer job table, bound to the top level.
module tjt_checker import tjt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // nothing left in the output register after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // an expiry names a real job with status ok
   a_expiry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[2:0] == STS_OK && rsp_tdata[6:3] != 4'd0)
      else $error("bad expiry result");

   // only tick expiries come in runs; errors are single and carry no id
   a_non_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[0])
      else $error("non-final result that is not an expiry");

   a_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != STS_OK |->
         rsp_tdata[6:3] == 4'd0 && rsp_tlast && !rsp_tuser[0] && rsp_tdata[7] == 1'b0)
      else $error("error result malformed");

endmodule

bind timer_job_table tjt_checker u_tjt_checker (.*);

>>> tb/tjt_checker.sv
// Scoreboard for the timer job table: mirrors the slot table and checks every result transfer.
module tjt_scoreboard import tjt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [31:0]      req_tdata,   // delay_ms[23:0], job_kind[25:24], job_id[29:26]
   input  logic [1:0]       req_tuser,   // command
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [7:0]       rsp_tdata,   // status[2:0], result_id[6:3]
   input  logic [0:0]       rsp_tuser,   // expired
   input  logic             rsp_tlast,
   input  logic             csr_wr_en,
   input  logic [RES_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] job;
      logic            expired;
      logic            fin;
   } job_result_type;

   job_result_type    job_result_q[$];
   job_result_type    got;
   job_result_type    want;
   logic [RES_W-1:0]  tick_res;
   logic [JOBS-1:0]   in_use;
   logic [JOBS-1:0]   is_periodic;
   logic [SDLY_W-1:0] job_delay [JOBS];
   logic [DLY_W-1:0]  job_elapsed [JOBS];

   function automatic job_result_type mk_result(logic [2:0] status, logic [ID_W-1:0] job,
                                                logic expired, logic fin);
      job_result_type r;
      r.status  = status;
      r.job     = job;
      r.expired = expired;
      r.fin     = fin;
      return r;
   endfunction

   task automatic free_slot(input int s);
      in_use[s]      = 1'b0;
      is_periodic[s] = 1'b0;
      job_delay[s]   = '0;
      job_elapsed[s] = '0;
   endtask

   // Works out what one command does to the table and queues its results.
   task automatic apply_command(input logic [1:0] cmd, input logic [31:0] data);
      logic [DLY_W-1:0] dly;
      logic [1:0]       kind;
      logic [ID_W-1:0]  id;
      int               slot;
      int               hits;
      dly  = data[23:0];
      kind = data[25:24];
      id   = data[29:26];
      slot = 0;
      hits = 0;
      case (cmd)
         CMD_START: begin
            for (int s = JOBS-1; s >= 1; s--)
               if (!in_use[s]) slot = s;
            if (slot == 0)
               job_result_q.push_back(mk_result(STS_FULL, '0, 1'b0, 1'b1));
            else if (dly > MAX_DELAY)
               job_result_q.push_back(mk_result(STS_BAD_DELAY, '0, 1'b0, 1'b1));
            else if (kind != KIND_ONESHOT && kind != KIND_PERIODIC)
               job_result_q.push_back(mk_result(STS_BAD_KIND, '0, 1'b0, 1'b1));
            else begin
               in_use[slot]      = 1'b1;
               is_periodic[slot] = (kind == KIND_PERIODIC);
               job_delay[slot]   = dly[SDLY_W-1:0];
               job_elapsed[slot] = '0;
               job_result_q.push_back(mk_result(STS_OK, slot[ID_W-1:0], 1'b0, 1'b1));
            end
         end
         CMD_STOP: begin
            if (id != 0 && int'(id) < JOBS && in_use[id]) begin
               free_slot(int'(id));
               job_result_q.push_back(mk_result(STS_OK, '0, 1'b0, 1'b1));
            end else
               job_result_q.push_back(mk_result(STS_NO_ID, '0, 1'b0, 1'b1));
         end
         CMD_TICK: begin
            for (int s = 1; s < JOBS; s++) begin
               if (in_use[s]) begin
                  job_elapsed[s] = job_elapsed[s] + DLY_W'(tick_res);
                  if (job_elapsed[s] >= DLY_W'(job_delay[s])) begin
                     job_elapsed[s] = '0;
                     job_result_q.push_back(mk_result(STS_OK, s[ID_W-1:0], 1'b1, 1'b0));
                     hits++;
                     if (!is_periodic[s]) free_slot(s);
                  end
               end
            end
            if (hits == 0)
               job_result_q.push_back(mk_result(STS_OK, '0, 1'b0, 1'b1));
            else
               job_result_q[job_result_q.size()-1].fin = 1'b1;
         end
         default: ;  // code 3 is dropped by the block
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         tick_res = 8'd1;
         for (int s = 0; s < JOBS; s++) free_slot(s);
         job_result_q.delete();
      end else begin
         // result side first: a result never belongs to a command accepted on the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = mk_result(rsp_tdata[2:0], rsp_tdata[6:3], rsp_tuser[0], rsp_tlast);
            if (job_result_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transfer: status %0d id %0d expired %0b last %0b",
                        $time, got.status, got.job, got.expired, got.fin);
            end else begin
               want = job_result_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: result mismatch: expected status %0d id %0d expired %0b last %0b",
                           $time, want.status, want.job, want.expired, want.fin);
                  $display("%0t:                  actual status %0d id %0d expired %0b last %0b",
                           $time, got.status, got.job, got.expired, got.fin);
               end
            end
         end
         if (req_tvalid && req_tready) apply_command(req_tuser, req_tdata);
         if (csr_wr_en) tick_res = csr_wr_data;
      end
      pending = job_result_q.size();
   end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the timer job table, with the scoreboard alongside the block.
module tb_top import tjt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_IGNORED = 2'd3;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata   = '0;
   logic [1:0]       req_tuser   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [7:0]       rsp_tdata;
   logic [0:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_wr_en   = 1'b0;
   logic [RES_W-1:0] csr_wr_data = '0;

   int               fail_count;
   int               pending;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_left     = 0;
   bit               hold_req      = 1'b0;
   bit               hold_served   = 1'b0;
   logic [RES_W-1:0] cur_res       = 8'd1;
   logic [RES_W-1:0] res_plan [6];

   timer_job_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tjt_scoreboard chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL timer_job_table");
      $finish;
   end

   // Result side: random back-pressure, plus long hold-offs that fill the block up.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left == 0 && hold_req && !hold_served) begin
            hold_left   = $urandom_range(150, 300);
            hold_served = 1'b1;
         end else if (hold_left == 0 && $urandom_range(0, 1999) == 0) begin
            hold_left = $urandom_range(150, 300);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else
            rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_cmd(input logic [1:0] cmd, input logic [DLY_W-1:0] dly,
                           input logic [1:0] kind, input logic [ID_W-1:0] id);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {2'b00, id, kind, dly};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      // a dropped code-3 command may still be in flight
      repeat (JOBS + 8) @(negedge clock);
   endtask

   task automatic write_resolution(input logic [RES_W-1:0] v);
      csr_wr_en   = 1'b1;
      csr_wr_data = v;
      cur_res     = v;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   function automatic logic [DLY_W-1:0] pick_delay();
      int k;
      k = $urandom_range(0, 99);
      if (k < 40)      return DLY_W'($urandom_range(0, 15));
      else if (k < 60) return DLY_W'($urandom_range(0, int'(cur_res) * 6 + 20));
      else if (k < 72) return DLY_W'($urandom_range(0, int'(MAX_DELAY)));
      else if (k < 80) return MAX_DELAY + DLY_W'($urandom_range(0, 1));
      else             return DLY_W'($urandom());
   endfunction

   function automatic logic [1:0] pick_kind();
      if ($urandom_range(0, 99) < 88) return 2'($urandom_range(0, 1));
      return 2'($urandom_range(2, 3));
   endfunction

   task automatic rand_start();
      send_cmd(CMD_START, pick_delay(), pick_kind(), 4'($urandom()));
   endtask

   task automatic rand_stop();
      logic [ID_W-1:0] id;
      id = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(1, JOBS-1)) : '0;
      send_cmd(CMD_STOP, 24'($urandom()), 2'($urandom()), id);
   endtask

   task automatic rand_tick();
      send_cmd(CMD_TICK, 24'($urandom()), 2'($urandom()), 4'($urandom()));
   endtask

   // Mostly bursts that fill, tick and empty the table; the rest single commands and noise.
   task automatic random_batch(input int n_items);
      int done;
      int k;
      int n;
      done = 0;
      while (done < n_items) begin
         k = $urandom_range(0, 99);
         if (k < 25) begin
            n = $urandom_range(4, JOBS);
            repeat (n) rand_start();
         end else if (k < 42) begin
            n = $urandom_range(2, 8);
            repeat (n) rand_tick();
         end else if (k < 52) begin
            n = $urandom_range(2, 8);
            repeat (n) rand_stop();
         end else if (k < 94) begin
            n = 1;
            case ($urandom_range(0, 2))
               0:       rand_start();
               1:       rand_stop();
               default: rand_tick();
            endcase
         end else begin
            n = 0;
            send_cmd(CMD_IGNORED, 24'($urandom()), 2'($urandom()), 4'($urandom()));
         end
         done += n;
      end
   endtask

   initial begin
      res_plan[0] = 8'd255;
      res_plan[1] = 8'd1;
      res_plan[2] = 8'($urandom_range(2, 254));
      res_plan[3] = 8'd3;
      res_plan[4] = 8'd255;
      res_plan[5] = 8'($urandom_range(1, 255));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 19;
      recv_idle_pct = 78;
      // directed part, tick resolution still at its reset value
      send_cmd(CMD_TICK,  24'd0,        2'd0,          4'd0);   // empty table
      send_cmd(CMD_STOP,  24'hFFFFFF,   2'd3,          4'd0);   // reserved slot
      send_cmd(CMD_STOP,  24'd0,        2'd0,          4'd15);  // free slot
      send_cmd(CMD_START, 24'd0,        KIND_ONESHOT,  4'd15);  // zero delay
      send_cmd(CMD_START, MAX_DELAY,    KIND_PERIODIC, 4'd0);
      send_cmd(CMD_START, MAX_DELAY + DLY_W'(1), KIND_ONESHOT, 4'd0);
      send_cmd(CMD_START, 24'hFFFFFF,   2'd3,          4'd0);   // delay checked before kind
      send_cmd(CMD_START, 24'd5,        2'd2,          4'd0);
      send_cmd(CMD_START, 24'd5,        2'd3,          4'd0);
      send_cmd(CMD_START, 24'd2,        KIND_PERIODIC, 4'd0);
      send_cmd(CMD_START, 24'd1,        KIND_ONESHOT,  4'd0);
      send_cmd(CMD_TICK,  24'd0,        2'd0,          4'd0);   // several expire at once
      send_cmd(CMD_TICK,  24'd0,        2'd0,          4'd0);   // periodic one expires
      send_cmd(CMD_STOP,  24'd0,        2'd0,          4'd2);
      send_cmd(CMD_STOP,  24'd0,        2'd0,          4'd2);   // already freed
      send_cmd(CMD_IGNORED, 24'hFFFFFF, 2'd3,          4'd15);  // dropped
      send_cmd(CMD_TICK,  24'd0,        2'd0,          4'd0);
      send_cmd(CMD_STOP,  24'd0,        2'd0,          4'd3);
      send_cmd(CMD_TICK,  24'd0,        2'd0,          4'd0);
      drain();

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_resolution(res_plan[p]);
         if (p == 0) hold_req = 1'b1;
         random_batch(75);
         drain();
      end

      if (fail_count == 0)
         $display("PASS timer_job_table");
      else
         $display("FAIL timer_job_table");
      $finish;
   end

endmodule
